// ===== sv/gri_pkg.sv =====
package gri_pkg;

	localparam int CORDIC_STEPS_DEF = 20;

	localparam int RAW_W  = 16;
	localparam int TS_W   = 32;
	localparam int OFF_W  = 32;
	localparam int ACC_W  = 48;
	localparam int RATE_W = 33;
	localparam int TILT_W = 24;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;
	localparam int REM_W  = 25;
	localparam int ANG_W  = 27;
	localparam int CR_W   = 36;
	localparam int ROOT_W = 32;
	localparam int SREM_W = 33;
	localparam int ATAN_W = 23;

	localparam int RATE_STEPS = 66;
	localparam int MOD_STEPS  = 48;
	localparam int SQRT_STEPS = 32;
	localparam int CNT_W      = 7;

	localparam logic signed [33:0] RAW_SCALE = 34'sd2000;
	localparam logic [REM_W-1:0] RATE_DIV = 25'd1000000;
	localparam logic [REM_W-1:0] MOD_DIV  = 25'd23592960;
	localparam logic [PROD_W-1:0] ROUND_HALF = 66'd500000;

	localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;
	localparam logic [TILT_W-1:0] TILT_MAX = 24'd11796480;
	localparam logic signed [CR_W-1:0] ONE_Q30 = 36'sh0_4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_ROLL  = 2'd0,
		REG_OFFSET_PITCH = 2'd1,
		REG_OFFSET_YAW   = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RATE,
		ST_LOAD,
		ST_MUL,
		ST_ROUND,
		ST_DIV,
		ST_ACC,
		ST_MLOAD,
		ST_MOD,
		ST_FOLD,
		ST_ROT,
		ST_PLOAD,
		ST_PMUL,
		ST_PFIX,
		ST_QLOAD,
		ST_SQMUL,
		ST_SQLD,
		ST_SQRT,
		ST_VLOAD,
		ST_VEC,
		ST_DONE
	} state_t;

	// arctangent of 2^-i in 2^-16 degrees
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
		logic [ATAN_W-1:0] v;
		unique case (i)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// squared cordic gain in q30
	function automatic logic [63:0] k2_q30(input int n);
		logic [63:0] g;
		g = 64'h4000_0000;
		for (int i = 0; i < n; i++) begin
			if (2 * i < 64) begin
				g = g + (g >> (2 * i));
			end
		end
		return g;
	endfunction

endpackage

// ===== sv/gyro_rate_integrator_top.sv =====
// channel   dir  handshake                fields
// in        in   in_valid / in_stall      raw_x raw_y raw_z timestamp_us zero_angles
// out       out  out_valid / out_stall    roll_angle pitch_angle yaw_angle tilt_angle roll_rate
// cfg       in   cfg_valid / cfg_ready    cfg_index cfg_data
//
// the work of each item goes to the bit-serial 66-step rate divide, the 48-step angle reduction,
// three 33-step shift-add multiplies, the 32-step square root and the two cordic passes
// in_stall is high from accept until the block is back in idle
// a finished result waits in the output register; done holds while it is full and stalled
// arst_n clears offsets, angles, last timestamp and control; cfg_ready is always high
module gyro_rate_integrator_top #(
	parameter int CORDIC_STEPS = gri_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [gri_pkg::RAW_W-1:0]      raw_x,
	input  logic signed [gri_pkg::RAW_W-1:0]      raw_y,
	input  logic signed [gri_pkg::RAW_W-1:0]      raw_z,
	input  logic        [gri_pkg::TS_W-1:0]       timestamp_us,
	input  logic                                  zero_angles,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [gri_pkg::ACC_W-1:0]      roll_angle,
	output logic signed [gri_pkg::ACC_W-1:0]      pitch_angle,
	output logic signed [gri_pkg::ACC_W-1:0]      yaw_angle,
	output logic        [gri_pkg::TILT_W-1:0]     tilt_angle,
	output logic signed [gri_pkg::RATE_W-1:0]     roll_rate,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [gri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [gri_pkg::OFF_W-1:0]      cfg_data
);
	import gri_pkg::*;

	localparam logic [63:0] G_Q30 = k2_q30(CORDIC_STEPS);
	localparam logic signed [33:0] G_S = 34'(G_Q30);
	localparam logic [63:0] G_SQ = G_Q30 * G_Q30;

	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(RATE_STEPS - 1);
	localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(MOD_STEPS - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
	localparam logic [CNT_W-1:0] CRD_LAST  = CNT_W'(CORDIC_STEPS - 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic cnt_last;
	logic in_fire, out_fire, done_fire;
	logic out_valid_q;

	logic signed [OFF_W-1:0]  off_q [3];
	logic signed [ACC_W-1:0]  acc_q [3];
	logic        [TS_W-1:0]   last_time_q;

	logic signed [RAW_W-1:0]  raw_q [3];
	logic                     zero_q;
	logic        [TS_W-1:0]   dt_q;
	logic signed [RATE_W-1:0] rate_q [3];
	logic                     neg_q [3];
	logic        [MUL_W-1:0]  bm_q [3];
	logic        [PROD_W-1:0] w_q [3];
	logic        [REM_W-1:0]  rem_q [3];
	logic signed [CR_W-1:0]   cx_q [2];
	logic signed [CR_W-1:0]   cy_q [2];
	logic signed [ANG_W-1:0]  cz_q [2];
	logic                     cneg_q [2];
	logic signed [33:0]       p_q;
	logic        [ROOT_W-1:0] root_q;
	logic        [SREM_W-1:0] srem_q;

	logic signed [ACC_W-1:0]  roll_q, pitch_q, yaw_q;
	logic        [TILT_W-1:0] tilt_q;
	logic signed [RATE_W-1:0] rr_q;

	// combinational datapath
	logic signed [33:0]       scaled [3];
	logic signed [33:0]       rate_c [3];
	logic signed [ACC_W-1:0]  acc_nxt [3];
	logic        [PROD_W-1:0] mul_w [3];
	logic        [PROD_W-1:0] div_w [3];
	logic        [REM_W-1:0]  div_rem [3];
	logic        [REM_W-1:0]  divisor;
	logic signed [ANG_W-1:0]  fold_r [2];
	logic                     fold_neg [2];
	logic        [MUL_W-1:0]  cabs [2];
	logic signed [63:0]       pprod;
	logic signed [33:0]       p_raw, p_clamp;
	logic        [MUL_W-1:0]  pabs;
	logic        [34:0]       sq_r2, sq_trial;
	logic signed [CR_W-1:0]   dx [2], dy [2];
	logic signed [ANG_W-1:0]  at;

	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;
	assign tilt_angle  = tilt_q;
	assign roll_rate   = rr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_last = 1'b0;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RATE;
			ST_RATE:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_MUL;
			ST_MUL: begin
				cnt_last = (cnt_q == MUL_LAST);
				if (cnt_last) state_d = ST_ROUND;
			end
			ST_ROUND: state_d = ST_DIV;
			ST_DIV: begin
				cnt_last = (cnt_q == DIV_LAST);
				if (cnt_last) state_d = ST_ACC;
			end
			ST_ACC:   state_d = ST_MLOAD;
			ST_MLOAD: state_d = ST_MOD;
			ST_MOD: begin
				cnt_last = (cnt_q == MOD_LAST);
				if (cnt_last) state_d = ST_FOLD;
			end
			ST_FOLD:  state_d = ST_ROT;
			ST_ROT: begin
				cnt_last = (cnt_q == CRD_LAST);
				if (cnt_last) state_d = ST_PLOAD;
			end
			ST_PLOAD: state_d = ST_PMUL;
			ST_PMUL: begin
				cnt_last = (cnt_q == MUL_LAST);
				if (cnt_last) state_d = ST_PFIX;
			end
			ST_PFIX:  state_d = ST_QLOAD;
			ST_QLOAD: state_d = ST_SQMUL;
			ST_SQMUL: begin
				cnt_last = (cnt_q == MUL_LAST);
				if (cnt_last) state_d = ST_SQLD;
			end
			ST_SQLD:  state_d = ST_SQRT;
			ST_SQRT: begin
				cnt_last = (cnt_q == SQRT_LAST);
				if (cnt_last) state_d = ST_VLOAD;
			end
			ST_VLOAD: state_d = ST_VEC;
			ST_VEC: begin
				cnt_last = (cnt_q == CRD_LAST);
				if (cnt_last) state_d = ST_DONE;
			end
			ST_DONE:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		divisor = (state_q == ST_MOD) ? MOD_DIV : RATE_DIV;
		at = ANG_W'(signed'({1'b0, atan_q16(cnt_q[4:0])}));
		for (int k = 0; k < 3; k++) begin
			logic [33:0] psum;
			logic [25:0] t;
			logic ge;
			logic [48:0] q49;
			logic signed [48:0] inc, sum;
			scaled[k] = 34'(raw_q[k]) * RAW_SCALE;
			// shift-add multiply, multiplier sits in the low half
			psum = {1'b0, w_q[k][65:33]} + {1'b0, (w_q[k][0] ? bm_q[k] : '0)};
			mul_w[k] = {psum, w_q[k][32:1]};
			// restoring divide by a constant, one quotient bit a cycle
			t = {rem_q[k], w_q[k][65]};
			ge = (t >= {1'b0, divisor});
			div_rem[k] = ge ? REM_W'(t - {1'b0, divisor}) : t[REM_W-1:0];
			div_w[k] = {w_q[k][64:0], ge};
			// signed increment, saturating add; cleared instead when zero is requested
			q49 = {1'b0, w_q[k][47:0]};
			inc = neg_q[k] ? -signed'(q49) : signed'(q49);
			sum = 49'(acc_q[k]) + inc;
			if (zero_q) begin
				acc_nxt[k] = '0;
			end else if (sum[48:47] == 2'b01) begin
				acc_nxt[k] = {1'b0, {(ACC_W-1){1'b1}}};
			end else if (sum[48:47] == 2'b10) begin
				acc_nxt[k] = {1'b1, {(ACC_W-1){1'b0}}};
			end else begin
				acc_nxt[k] = sum[ACC_W-1:0];
			end
		end
		rate_c[0] = -(scaled[0] + 34'(off_q[0]));
		rate_c[1] = scaled[1] - 34'(off_q[1]);
		rate_c[2] = scaled[2] - 34'(off_q[2]);
		for (int k = 0; k < 2; k++) begin
			logic signed [ANG_W-1:0] rm, r0, r1;
			logic signed [CR_W-1:0] ca;
			rm = ANG_W'(signed'({1'b0, rem_q[k+1]}));
			// floor modulo, then fold into the first quadrant
			r0 = (neg_q[k+1] && rm != '0) ? DEG360 - rm : rm;
			r1 = (r0 > DEG180) ? DEG360 - r0 : r0;
			fold_neg[k] = (r1 > DEG90);
			fold_r[k] = fold_neg[k] ? DEG180 - r1 : r1;
			ca = cx_q[k][CR_W-1] ? -cx_q[k] : cx_q[k];
			cabs[k] = ca[MUL_W-1:0];
			dx[k] = cy_q[k] >>> cnt_q[4:0];
			dy[k] = cx_q[k] >>> cnt_q[4:0];
		end
		pprod = neg_q[0] ? -signed'(w_q[0][63:0]) : signed'(w_q[0][63:0]);
		p_raw = pprod[63:30];
		if (p_raw > G_S) begin
			p_clamp = G_S;
		end else if (p_raw < -G_S) begin
			p_clamp = -G_S;
		end else begin
			p_clamp = p_raw;
		end
		pabs = p_q[33] ? MUL_W'(-p_q) : MUL_W'(p_q);
		sq_r2 = {srem_q, w_q[0][63:62]};
		sq_trial = {1'b0, root_q, 2'b01};
	end

	// control, configuration and angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_time_q <= '0;
			for (int k = 0; k < 3; k++) begin
				off_q[k] <= '0;
				acc_q[k] <= '0;
			end
		end else begin
			if (cnt_last || state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				last_time_q <= timestamp_us;
			end
			if (state_q == ST_ACC) begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= acc_nxt[k];
				end
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_OFFSET_ROLL:  off_q[0] <= cfg_data;
					REG_OFFSET_PITCH: off_q[1] <= cfg_data;
					REG_OFFSET_YAW:   off_q[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q[0] <= raw_x;
			raw_q[1] <= raw_y;
			raw_q[2] <= raw_z;
			zero_q   <= zero_angles;
			dt_q     <= timestamp_us - last_time_q;
		end
		unique case (state_q)
			ST_RATE: begin
				for (int k = 0; k < 3; k++) rate_q[k] <= rate_c[k][RATE_W-1:0];
			end
			ST_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= rate_q[k][RATE_W-1];
					bm_q[k]  <= rate_q[k][RATE_W-1] ? MUL_W'(-rate_q[k]) : MUL_W'(rate_q[k]);
					w_q[k]   <= {{(PROD_W-TS_W){1'b0}}, dt_q};
				end
			end
			ST_MUL, ST_PMUL, ST_SQMUL: begin
				for (int k = 0; k < 3; k++) w_q[k] <= mul_w[k];
			end
			ST_ROUND: begin
				for (int k = 0; k < 3; k++) begin
					w_q[k]   <= w_q[k] + ROUND_HALF;
					rem_q[k] <= '0;
				end
			end
			ST_DIV, ST_MOD: begin
				for (int k = 0; k < 3; k++) begin
					w_q[k]   <= div_w[k];
					rem_q[k] <= div_rem[k];
				end
			end
			ST_MLOAD: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= acc_q[k][ACC_W-1];
					w_q[k]   <= {(acc_q[k][ACC_W-1] ? -acc_q[k] : acc_q[k]),
						{(PROD_W-ACC_W){1'b0}}};
					rem_q[k] <= '0;
				end
			end
			ST_FOLD: begin
				for (int k = 0; k < 2; k++) begin
					cx_q[k]   <= ONE_Q30;
					cy_q[k]   <= '0;
					cz_q[k]   <= fold_r[k];
					cneg_q[k] <= fold_neg[k];
				end
			end
			ST_ROT: begin
				for (int k = 0; k < 2; k++) begin
					if (cz_q[k] >= 0) begin
						cx_q[k] <= cx_q[k] - dx[k];
						cy_q[k] <= cy_q[k] + dy[k];
						cz_q[k] <= cz_q[k] - at;
					end else begin
						cx_q[k] <= cx_q[k] + dx[k];
						cy_q[k] <= cy_q[k] - dy[k];
						cz_q[k] <= cz_q[k] + at;
					end
				end
			end
			ST_PLOAD: begin
				neg_q[0] <= cneg_q[0] ^ cx_q[0][CR_W-1] ^ cneg_q[1] ^ cx_q[1][CR_W-1];
				w_q[0]   <= {{(PROD_W-MUL_W){1'b0}}, cabs[0]};
				bm_q[0]  <= cabs[1];
			end
			ST_PFIX: p_q <= p_clamp;
			ST_QLOAD: begin
				w_q[0]  <= {{(PROD_W-MUL_W){1'b0}}, pabs};
				bm_q[0] <= pabs;
			end
			ST_SQLD: begin
				w_q[0]  <= {2'b00, G_SQ - w_q[0][63:0]};
				srem_q  <= '0;
				root_q  <= '0;
			end
			ST_SQRT: begin
				// two radicand bits per step
				if (sq_r2 >= sq_trial) begin
					srem_q <= SREM_W'(sq_r2 - sq_trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= sq_r2[SREM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				w_q[0] <= {w_q[0][PROD_W-3:0], 2'b00};
			end
			ST_VLOAD: begin
				// negative cosine product starts a quarter turn on
				if (p_q < 0) begin
					cx_q[0] <= CR_W'(signed'({1'b0, root_q}));
					cy_q[0] <= CR_W'(-p_q);
					cz_q[0] <= DEG90;
				end else begin
					cx_q[0] <= CR_W'(p_q);
					cy_q[0] <= CR_W'(signed'({1'b0, root_q}));
					cz_q[0] <= '0;
				end
			end
			ST_VEC: begin
				if (cy_q[0] >= 0) begin
					cx_q[0] <= cx_q[0] + dx[0];
					cy_q[0] <= cy_q[0] - dy[0];
					cz_q[0] <= cz_q[0] + at;
				end else begin
					cx_q[0] <= cx_q[0] - dx[0];
					cy_q[0] <= cy_q[0] + dy[0];
					cz_q[0] <= cz_q[0] - at;
				end
			end
			default: ;
		endcase
		if (done_fire) begin
			roll_q  <= acc_q[0];
			pitch_q <= acc_q[1];
			yaw_q   <= acc_q[2];
			rr_q    <= rate_q[0];
			if (cz_q[0] < 0) begin
				tilt_q <= '0;
			end else if (cz_q[0] > DEG180) begin
				tilt_q <= TILT_MAX;
			end else begin
				tilt_q <= cz_q[0][TILT_W-1:0];
			end
		end
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("block not busy after a request");

	a_last_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> last_time_q == $past(timestamp_us))
		else $error("last timestamp not taken");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q[0] < RATE_DIV))
		else $error("divider remainder out of range");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> ({1'b0, srem_q} <= {root_q, 2'b00}))
		else $error("square root remainder too large");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (tilt_q <= TILT_MAX))
		else $error("tilt out of range");

endmodule
